// ----- rtl/tlbl_pkg.sv -----
// Shared types and constants for the LRU translation buffer.
// Holds the sequencer state encoding and the control bundle that is driven into the cell chain.
// No dependencies.
package tlbl_pkg;

    localparam int unsigned ADDR_W = 32;
    localparam int unsigned CNT_W  = 32;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef enum logic {
        S_IDLE,
        S_EVAL
    } state_t;

    typedef struct packed {
        logic capture;
        logic update;
        logic insert;
    } cell_ctl_t;

endpackage

// ----- rtl/tlbl_cell.sv -----
// One entry of the recency-ordered translation chain.
// The cell holds a page tag, a frame address and a registered match flag, and shifts in its
// upper neighbour's entry when it moves down. Depends on tlbl_pkg.
module tlbl_cell #(
    parameter int unsigned TAG_W = 20
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  tlbl_pkg::cell_ctl_t          ctl,
    input  logic [TAG_W-1:0]             cmp_tag,
    input  logic [TAG_W-1:0]             tag_in,
    input  logic [tlbl_pkg::ADDR_W-1:0]  frame_in,
    input  logic                         above_in,
    input  logic [tlbl_pkg::ADDR_W-1:0]  sel_in,
    output logic [TAG_W-1:0]             tag_out,
    output logic [tlbl_pkg::ADDR_W-1:0]  frame_out,
    output logic                         above_out,
    output logic [tlbl_pkg::ADDR_W-1:0]  sel_out
);

    logic [TAG_W-1:0]            tag_reg;
    logic [tlbl_pkg::ADDR_W-1:0] frame_reg;
    logic                        match_reg;
    logic                        first;
    logic                        shift;

    assign first     = match_reg && !above_in;
    assign above_out = above_in || match_reg;
    assign sel_out   = sel_in | (first ? frame_reg : '0);
    assign shift     = ctl.update && (ctl.insert || !above_in);
    assign tag_out   = tag_reg;
    assign frame_out = frame_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg   <= '0;
            frame_reg <= '0;
            match_reg <= 1'b0;
        end else begin
            if (ctl.capture) begin
                match_reg <= (tag_reg == cmp_tag) && (frame_reg != '0);
            end
            if (shift) begin
                tag_reg   <= tag_in;
                frame_reg <= frame_in;
            end
        end
    end

endmodule

// ----- rtl/tlbl_chain.sv -----
// Row of translation cells ordered from most recent (cell 0) to least recent.
// Resolves the most recent match and moves entries towards the tail. Depends on tlbl_pkg and
// tlbl_cell.
module tlbl_chain #(
    parameter int unsigned ENTRIES = 16,
    parameter int unsigned TAG_W   = 20
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  tlbl_pkg::cell_ctl_t          ctl,
    input  logic [TAG_W-1:0]             cmp_tag,
    input  logic [TAG_W-1:0]             head_tag,
    input  logic [tlbl_pkg::ADDR_W-1:0]  insert_frame,
    output logic                         hit_any,
    output logic [tlbl_pkg::ADDR_W-1:0]  hit_frame
);

    logic [TAG_W-1:0]            tag_link   [ENTRIES];
    logic [tlbl_pkg::ADDR_W-1:0] frame_link [ENTRIES];
    logic                        above_link [ENTRIES];
    logic [tlbl_pkg::ADDR_W-1:0] sel_link   [ENTRIES];
    logic [tlbl_pkg::ADDR_W-1:0] head_frame;

    assign head_frame = ctl.insert ? insert_frame : hit_frame;
    assign hit_any    = above_link[ENTRIES-1];
    assign hit_frame  = sel_link[ENTRIES-1];

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        if (i == 0) begin : g_head
            tlbl_cell #(.TAG_W(TAG_W)) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctl       (ctl),
                .cmp_tag   (cmp_tag),
                .tag_in    (head_tag),
                .frame_in  (head_frame),
                .above_in  (1'b0),
                .sel_in    ('0),
                .tag_out   (tag_link[i]),
                .frame_out (frame_link[i]),
                .above_out (above_link[i]),
                .sel_out   (sel_link[i])
            );
        end else begin : g_body
            tlbl_cell #(.TAG_W(TAG_W)) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctl       (ctl),
                .cmp_tag   (cmp_tag),
                .tag_in    (tag_link[i-1]),
                .frame_in  (frame_link[i-1]),
                .above_in  (above_link[i-1]),
                .sel_in    (sel_link[i-1]),
                .tag_out   (tag_link[i]),
                .frame_out (frame_link[i]),
                .above_out (above_link[i]),
                .sel_out   (sel_link[i])
            );
        end
    end

endmodule

// ----- rtl/tlb_lru_lookup_insert_top.sv -----
// Fully associative translation buffer with true LRU replacement, top level.
// Holds the item sequencer, the hit and miss counters and the result register. Depends on
// tlbl_pkg and tlbl_chain.
//
// In the accepting cycle (S_IDLE) every cell compares its tag with the page number; then in
// S_EVAL, once the result side is free, the most recent match is resolved along the cell
// chain, the entries move and the result is registered. A new transaction is accepted only
// in S_IDLE, so one is not taken before the last has finished; the sequencer sets this.
// A lookup returns the stored physical address on a hit, otherwise zero; an insert always
// replaces the least recent entry. Both counters wrap at 32 bits.
module tlb_lru_lookup_insert_top #(
    parameter int unsigned ENTRIES   = 16,
    parameter int unsigned PAGE_BITS = 12
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // virt_addr [31:0], phys_addr [63:32]
    input  logic [0:0]   s_tuser,   // operation [0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // physical_page [31:0], hit_total [63:32], miss_total [95:64]
    output logic [0:0]   m_tuser    // hit [0]
);

    localparam int unsigned TAG_W = tlbl_pkg::ADDR_W - PAGE_BITS;

    tlbl_pkg::state_t             state_reg, state_next;
    tlbl_pkg::cell_ctl_t          ctl;
    logic                         op_reg;
    logic [TAG_W-1:0]             tag_reg;
    logic [tlbl_pkg::ADDR_W-1:0]  pa_reg;
    logic [tlbl_pkg::CNT_W-1:0]   hit_cnt_reg, hit_cnt_next;
    logic [tlbl_pkg::CNT_W-1:0]   miss_cnt_reg, miss_cnt_next;
    logic                         m_valid_reg;
    logic                         hit_reg;
    logic [tlbl_pkg::ADDR_W-1:0]  page_reg;
    logic                         s_accept;
    logic                         out_free;
    logic                         finish;
    logic                         hit_any;
    logic [tlbl_pkg::ADDR_W-1:0]  hit_frame;
    logic                         res_hit;
    logic [TAG_W-1:0]             in_tag;

    assign in_tag   = s_tdata[tlbl_pkg::ADDR_W-1:PAGE_BITS];
    assign s_tready = (state_reg == tlbl_pkg::S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign res_hit  = (op_reg == tlbl_pkg::OP_LOOKUP) && hit_any;

    always_comb begin
        state_next    = state_reg;
        finish        = 1'b0;
        ctl.capture   = 1'b0;
        ctl.update    = 1'b0;
        ctl.insert    = (op_reg == tlbl_pkg::OP_INSERT);
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        unique case (state_reg)
            tlbl_pkg::S_IDLE: begin
                if (s_accept) begin
                    ctl.capture = 1'b1;
                    state_next  = tlbl_pkg::S_EVAL;
                end
            end
            tlbl_pkg::S_EVAL: begin
                if (out_free) begin
                    finish     = 1'b1;
                    ctl.update = ctl.insert || hit_any;
                    state_next = tlbl_pkg::S_IDLE;
                    if (op_reg == tlbl_pkg::OP_LOOKUP) begin
                        if (hit_any) begin
                            hit_cnt_next = hit_cnt_reg + 1'b1;
                        end else begin
                            miss_cnt_next = miss_cnt_reg + 1'b1;
                        end
                    end
                end
            end
            default: begin
                state_next = tlbl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= tlbl_pkg::S_IDLE;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
            op_reg       <= tlbl_pkg::OP_LOOKUP;
        end else begin
            state_reg    <= state_next;
            hit_cnt_reg  <= hit_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (s_accept) begin
                op_reg <= s_tuser[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            tag_reg <= in_tag;
            pa_reg  <= s_tdata[63:32];
        end
        if (finish) begin
            hit_reg  <= res_hit;
            page_reg <= res_hit ? hit_frame : '0;
        end
    end

    tlbl_chain #(
        .ENTRIES (ENTRIES),
        .TAG_W   (TAG_W)
    ) u_chain (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctl          (ctl),
        .cmp_tag      (in_tag),
        .head_tag     (tag_reg),
        .insert_frame (pa_reg),
        .hit_any      (hit_any),
        .hit_frame    (hit_frame)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = hit_reg;
    assign m_tdata  = {miss_cnt_reg, hit_cnt_reg, page_reg};

    a_result_after_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == tlbl_pkg::S_EVAL))
        else $error("result appeared without an evaluation cycle");

    a_hit_has_page: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[31:0] != '0))
        else $error("hit reported with a zero physical page");

    a_insert_no_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (finish && op_reg == tlbl_pkg::OP_INSERT) |=> (!m_tuser[0] && $stable(hit_cnt_reg)
            && $stable(miss_cnt_reg)))
        else $error("insert changed the counters or reported a hit");

    a_stall_holds_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tlbl_pkg::S_EVAL && !out_free) |=> ($stable(hit_cnt_reg)
            && $stable(miss_cnt_reg)))
        else $error("counters moved while the result was stalled");

endmodule
